// File: design/pkv_pkg.sv
package pkv_pkg;

    // Default sizing of the block pool and the per-sequence tables.
    localparam int DEF_POOL_BLOCKS = 1024;
    localparam int DEF_SEQ_SLOTS   = 64;
    localparam int DEF_TABLE_DEPTH = 256;

    // Divider operand widths: the reserve sum needs 19 bits; the divisor port is 11 bits.
    localparam int DVD_W = 19;
    localparam int DVS_W = 11;

    // Command codes.
    localparam logic [1:0] CMD_RESERVE   = 2'd0;
    localparam logic [1:0] CMD_RELEASE   = 2'd1;
    localparam logic [1:0] CMD_TRANSLATE = 2'd2;

    // Store codes.
    localparam logic [1:0] STORE_KEY     = 2'd0;
    localparam logic [1:0] STORE_VALUE   = 2'd1;
    localparam logic [1:0] STORE_INDEXER = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXHAUSTED = 3'd1;
    localparam logic [2:0] ST_TBL_FULL  = 3'd2;
    localparam logic [2:0] ST_UNMAPPED  = 3'd3;
    localparam logic [2:0] ST_IDX_OFF   = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
    localparam logic [2:0] REG_KV_HEADS    = 3'd1;
    localparam logic [2:0] REG_HEAD_WIDTH  = 3'd2;
    localparam logic [2:0] REG_TOKENS_BLK  = 3'd3;
    localparam logic [2:0] REG_POOL_BLOCKS = 3'd4;
    localparam logic [2:0] REG_IDX_WIDTH   = 3'd5;

    // Divider status toward the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// File: design/pkv_ram.sv
module pkv_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/pkv_div.sv
module pkv_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [pkv_pkg::DVD_W-1:0] dividend,
    input  logic [pkv_pkg::DVS_W-1:0] divisor,
    output logic [pkv_pkg::DVD_W-1:0] quot,
    output logic [pkv_pkg::DVS_W-1:0] rem,
    output pkv_pkg::div_stat_t        stat
);

    import pkv_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] work_reg;
    logic [DVS_W-1:0] part_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DVS_W:0]   trial;
    logic             ge;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign trial = {part_reg, work_reg[DVD_W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                work_reg <= dividend;
                part_reg <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                work_reg <= {work_reg[DVD_W-2:0], ge};
                part_reg <= ge ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quot      = work_reg;
    assign rem       = part_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: design/paged_kv_block_manager_core.sv
// Sequence: each command reads its fill count and makes one 19-step pass of the shared
// bit-serial divider; reserve then pops blocks, release returns them, a mapped translate
// reads its table entry and runs S_M0 to S_M3; errors and command three go to the result.
// Throughput: one command at a time; the next is taken the cycle after the result is loaded.
// Reset: registers take their defaults, the free stack reads as descending ids with
// block zero on top, and every block table is empty; no clearing pass is needed.
module paged_kv_block_manager_core #(
    parameter int POOL_BLOCKS = pkv_pkg::DEF_POOL_BLOCKS,
    parameter int SEQ_SLOTS   = pkv_pkg::DEF_SEQ_SLOTS,
    parameter int TABLE_DEPTH = pkv_pkg::DEF_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // Command stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: seq_slot[5:0], seq_length[22:6], extra_tokens[39:23],
    // layer_index[46:40], token_position[62:47], store_select[64:63], zero fill
    input  logic [71:0] s_tdata,
    // s_tuser: command[1:0]
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: element_offset[39:0], store_used[41:40], blocks_held[50:42],
    // free_blocks[61:51], zero fill
    output logic [63:0] m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]  m_tuser,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import pkv_pkg::*;

    localparam int BW   = $clog2(POOL_BLOCKS);
    localparam int TW   = $clog2(POOL_BLOCKS + 1);
    localparam int SW   = SEQ_SLOTS > 1 ? $clog2(SEQ_SLOTS) : 1;
    localparam int FW   = $clog2(TABLE_DEPTH + 1);
    localparam int KW   = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
    localparam int TAW  = (SEQ_SLOTS * TABLE_DEPTH) > 1 ?
                          $clog2(SEQ_SLOTS * TABLE_DEPTH) : 1;
    localparam int RST_POOL = POOL_BLOCKS < 1024 ? POOL_BLOCKS : 1024;

    typedef enum logic [3:0] {
        S_IDLE, S_RDF, S_GOT, S_DIV, S_POP, S_POPW, S_REL, S_RELW,
        S_TRD, S_M0, S_M1, S_M2, S_M3, S_DONE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [7:0]  layer_count_reg;
    logic [7:0]  kv_heads_reg;
    logic [8:0]  head_width_reg;
    logic [8:0]  tokens_per_block_reg;
    logic [10:0] blocks_in_pool_reg;
    logic [10:0] indexer_width_reg;

    // Command context.
    logic [1:0]       cmd_reg;
    logic [SW-1:0]    slot_reg;
    logic [DVD_W-1:0] dividend_reg;
    logic [6:0]       layer_reg;
    logic [1:0]       used_reg;
    logic [FW-1:0]    fill_reg;
    logic [DVD_W-1:0] q_reg;
    logic [8:0]       rem_reg;
    logic [FW-1:0]    k_reg;
    logic [BW-1:0]    phys_reg;
    logic [16:0]      tw_reg;
    logic [48:0]      acc_reg;
    logic [2:0]       status_reg;

    // Free stack control and per-slot fill valid bits.
    logic [TW-1:0]        top_reg;
    logic [TW-1:0]        min_reg;
    logic [SEQ_SLOTS-1:0] fill_valid_reg;

    // Result register.
    logic        m_valid_reg;
    logic [2:0]  o_status_reg;
    logic [39:0] o_offset_reg;
    logic [1:0]  o_used_reg;
    logic [8:0]  o_held_reg;
    logic [10:0] o_free_reg;

    // Effective register values.
    logic [8:0]    bs;
    logic [7:0]    lc1;
    logic [7:0]    h1;
    logic [8:0]    w1;
    logic [10:0]   bp0;
    logic [10:0]   wp0;
    logic [TW-1:0] pool_eff;
    logic [TW-1:0] wpool_eff;

    assign bs  = tokens_per_block_reg == '0 ? 9'd1 : tokens_per_block_reg;
    assign lc1 = layer_count_reg == '0 ? 8'd1 : layer_count_reg;
    assign h1  = kv_heads_reg == '0 ? 8'd1 : kv_heads_reg;
    assign w1  = head_width_reg == '0 ? 9'd1 : head_width_reg;
    assign bp0 = blocks_in_pool_reg == '0 ? 11'd1 : blocks_in_pool_reg;
    assign wp0 = pwdata[10:0] == '0 ? 11'd1 : pwdata[10:0];
    assign pool_eff  = 32'(bp0) > 32'(POOL_BLOCKS) ? TW'(POOL_BLOCKS) : TW'(bp0);
    assign wpool_eff = 32'(wp0) > 32'(POOL_BLOCKS) ? TW'(POOL_BLOCKS) : TW'(wp0);

    // Input handshake and configuration strobe.
    logic accept;
    logic cfg_wr;

    assign s_tready = state_reg == S_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    // Slot wrap table: every 6-bit slot number mapped onto the slots present.
    logic [SW-1:0] slot_map [64];

    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            slot_map[i] = SW'(i % SEQ_SLOTS);
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[4:2])
            REG_LAYER_COUNT: prdata = 32'(layer_count_reg);
            REG_KV_HEADS:    prdata = 32'(kv_heads_reg);
            REG_HEAD_WIDTH:  prdata = 32'(head_width_reg);
            REG_TOKENS_BLK:  prdata = 32'(tokens_per_block_reg);
            REG_POOL_BLOCKS: prdata = 32'(blocks_in_pool_reg);
            REG_IDX_WIDTH:   prdata = 32'(indexer_width_reg);
            default:         prdata = '0;
        endcase
    end

    // Shared divider: block count for reserve, block index and offset for translate.
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic [DVD_W-1:0] div_quot;
    logic [DVS_W-1:0] div_rem;
    div_stat_t        div_stat;

    assign div_start = state_reg == S_RDF;
    assign div_dvd   = dividend_reg;
    assign div_dvs   = DVS_W'(bs);

    pkv_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quot     (div_quot),
        .rem      (div_rem),
        .stat     (div_stat)
    );

    // Shared multiplier for the address arithmetic.
    logic [31:0] mul_a;
    logic [16:0] mul_b;
    logic [48:0] mul_p;

    always_comb
    begin
        unique case (state_reg)
            S_M0:
            begin
                mul_a = 32'(h1);
                mul_b = 17'(w1);
            end
            S_M1:
            begin
                mul_a = 32'(layer_reg);
                mul_b = 17'(pool_eff);
            end
            S_M2:
            begin
                mul_a = acc_reg[31:0] + 32'(phys_reg);
                mul_b = 17'(bs);
            end
            default:
            begin
                mul_a = acc_reg[31:0] + 32'(rem_reg);
                mul_b = tw_reg;
            end
        endcase
    end

    assign mul_p = 49'(mul_a) * 49'(mul_b);

    // Loop conditions.
    logic          can_pop;
    logic          rel_more;
    logic [TW-1:0] pop_idx;

    assign can_pop  = (DVD_W'(fill_reg) < q_reg) && top_reg != '0;
    assign rel_more = k_reg < fill_reg;
    assign pop_idx  = top_reg - 1'b1;

    // Fill count memory.
    logic          fill_we;
    logic [FW-1:0] fill_wdata;
    logic [FW-1:0] fill_rdata;

    assign fill_we    = (state_reg == S_POP && !can_pop) || (state_reg == S_REL && !rel_more);
    assign fill_wdata = state_reg == S_REL ? '0 : fill_reg;

    pkv_ram #(.WIDTH(FW), .DEPTH(SEQ_SLOTS)) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (slot_reg),
        .wdata (fill_wdata),
        .raddr (slot_reg),
        .rdata (fill_rdata)
    );

    // Block table read data, shared by release and translate.
    logic [BW-1:0]  tbl_rdata;

    // Free stack memory; entries below the low mark read as their refill ids, computed, not stored.
    logic          stk_we;
    logic [BW-1:0] stk_rdata;
    logic [BW-1:0] pop_blk;

    assign stk_we  = state_reg == S_RELW && 32'(top_reg) < POOL_BLOCKS;
    assign pop_blk = pop_idx < min_reg ? BW'(pool_eff - 1'b1 - pop_idx) : stk_rdata;

    pkv_ram #(.WIDTH(BW), .DEPTH(POOL_BLOCKS)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (BW'(top_reg)),
        .wdata (tbl_rdata),
        .raddr (BW'(pop_idx)),
        .rdata (stk_rdata)
    );

    // Block table memory, one row of TABLE_DEPTH entries per slot.
    logic           tbl_we;
    logic [TAW-1:0] tbl_base;
    logic [TAW-1:0] tbl_waddr;
    logic [TAW-1:0] tbl_raddr;

    assign tbl_we    = state_reg == S_POPW;
    assign tbl_base  = TAW'(slot_reg) * TAW'(TABLE_DEPTH);
    assign tbl_waddr = tbl_base + TAW'(fill_reg[KW-1:0]);
    assign tbl_raddr = state_reg == S_DIV ? tbl_base + TAW'(div_quot[KW-1:0])
                                          : tbl_base + TAW'(k_reg[KW-1:0]);

    pkv_ram #(.WIDTH(BW), .DEPTH(SEQ_SLOTS * TABLE_DEPTH)) u_table_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (pop_blk),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Sequencer, configuration registers and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            layer_count_reg      <= 8'd1;
            kv_heads_reg         <= 8'd1;
            head_width_reg       <= 9'd128;
            tokens_per_block_reg <= 9'd16;
            blocks_in_pool_reg   <= 11'd1024;
            indexer_width_reg    <= '0;
            top_reg              <= TW'(RST_POOL);
            min_reg              <= TW'(RST_POOL);
            fill_valid_reg       <= '0;
            m_valid_reg          <= 1'b0;
        end
        else
        begin
            // A waiting result leaves when taken, unless a new one replaces it.
            if (m_valid_reg && m_tready && state_reg != S_DONE)
            begin
                m_valid_reg <= 1'b0;
            end

            // Configuration writes; a pool write refills the stack and empties tables.
            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    REG_LAYER_COUNT: layer_count_reg      <= pwdata[7:0];
                    REG_KV_HEADS:    kv_heads_reg         <= pwdata[7:0];
                    REG_HEAD_WIDTH:  head_width_reg       <= pwdata[8:0];
                    REG_TOKENS_BLK:  tokens_per_block_reg <= pwdata[8:0];
                    REG_POOL_BLOCKS:
                    begin
                        blocks_in_pool_reg <= pwdata[10:0];
                        top_reg            <= wpool_eff;
                        min_reg            <= wpool_eff;
                        fill_valid_reg     <= '0;
                    end
                    REG_IDX_WIDTH:   indexer_width_reg    <= pwdata[10:0];
                    default:         ;
                endcase
            end

            if (fill_we)
            begin
                fill_valid_reg[slot_reg] <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg    <= s_tuser;
                        slot_reg   <= slot_map[s_tdata[5:0]];
                        layer_reg  <= s_tdata[46:40];
                        status_reg <= ST_OK;
                        if (s_tuser == CMD_RESERVE)
                        begin
                            dividend_reg <= DVD_W'(s_tdata[22:6]) + DVD_W'(s_tdata[39:23])
                                          + DVD_W'(bs) - 1'b1;
                        end
                        else
                        begin
                            dividend_reg <= DVD_W'(s_tdata[62:47]);
                        end
                        if (s_tuser == CMD_TRANSLATE)
                        begin
                            case (s_tdata[64:63])
                                STORE_INDEXER: used_reg <= STORE_INDEXER;
                                STORE_VALUE:   used_reg <= STORE_VALUE;
                                default:       used_reg <= STORE_KEY;
                            endcase
                        end
                        else
                        begin
                            used_reg <= STORE_KEY;
                        end
                        state_reg <= S_RDF;
                    end
                end
                S_RDF:
                begin
                    state_reg <= S_GOT;
                end
                S_GOT:
                begin
                    fill_reg  <= fill_valid_reg[slot_reg] ? fill_rdata : '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        q_reg   <= div_quot;
                        rem_reg <= div_rem[8:0];
                        k_reg   <= '0;
                        unique case (cmd_reg)
                            CMD_RESERVE:
                            begin
                                if (32'(div_quot) > TABLE_DEPTH)
                                begin
                                    status_reg <= ST_TBL_FULL;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_POP;
                                end
                            end
                            CMD_RELEASE:
                            begin
                                state_reg <= S_REL;
                            end
                            CMD_TRANSLATE:
                            begin
                                if (used_reg == STORE_INDEXER && indexer_width_reg == '0)
                                begin
                                    status_reg <= ST_IDX_OFF;
                                    state_reg  <= S_DONE;
                                end
                                else if (div_quot >= DVD_W'(fill_reg) ||
                                         8'(layer_reg) >= lc1)
                                begin
                                    status_reg <= ST_UNMAPPED;
                                    state_reg  <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_TRD;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_POP:
                begin
                    if (can_pop)
                    begin
                        state_reg <= S_POPW;
                    end
                    else
                    begin
                        if (DVD_W'(fill_reg) < q_reg)
                        begin
                            status_reg <= ST_EXHAUSTED;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_POPW:
                begin
                    fill_reg <= fill_reg + 1'b1;
                    top_reg  <= pop_idx;
                    if (pop_idx < min_reg)
                    begin
                        min_reg <= pop_idx;
                    end
                    state_reg <= S_POP;
                end
                S_REL:
                begin
                    if (rel_more)
                    begin
                        state_reg <= S_RELW;
                    end
                    else
                    begin
                        fill_reg  <= '0;
                        state_reg <= S_DONE;
                    end
                end
                S_RELW:
                begin
                    if (stk_we)
                    begin
                        top_reg <= top_reg + 1'b1;
                    end
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= S_REL;
                end
                S_TRD:
                begin
                    state_reg <= S_M0;
                end
                S_M0:
                begin
                    tw_reg    <= used_reg == STORE_INDEXER ? 17'(indexer_width_reg)
                                                           : mul_p[16:0];
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    acc_reg   <= mul_p;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg  <= 1'b1;
                        o_status_reg <= status_reg;
                        o_offset_reg <= (cmd_reg == CMD_TRANSLATE && status_reg == ST_OK)
                                        ? acc_reg[39:0] : '0;
                        o_used_reg   <= used_reg;
                        o_held_reg   <= 9'(fill_reg);
                        o_free_reg   <= 11'(top_reg);
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // The translated block id arrives in the cycle after the table read.
            if (state_reg == S_TRD)
            begin
                phys_reg <= tbl_rdata;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_status_reg;
    assign m_tdata  = {2'b00, o_free_reg, o_held_reg, o_used_reg, o_offset_reg};

    // The stack count never exceeds the pool.
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(top_reg) <= POOL_BLOCKS)
        else $error("free stack count above pool size");

    // A transfer in closes the input until the result is loaded.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("command taken while busy");

    // Stored fill counts stay within a table.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_we |-> 32'(fill_wdata) <= TABLE_DEPTH)
        else $error("fill count beyond table depth");

    // The divider finishes only where the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV)
        else $error("divider result not expected");

endmodule

// File: tb/tb_paged_kv_block_manager_core.sv
`timescale 1ns / 100ps

module tb_paged_kv_block_manager_core;

    import pkv_pkg::*;

    // Codes that the package leaves unnamed, and the sizes the bench assumes.
    localparam logic [1:0] CMD_IDLE_OP = 2'd3;
    localparam logic [1:0] STORE_SPARE = 2'd3;
    localparam int         POOL_MAX    = 1024;
    localparam int         SLOTS       = 64;
    localparam int         DEPTH       = 256;

    typedef struct packed {
        logic [1:0]  command;
        logic [5:0]  slot;
        logic [16:0] seq_length;
        logic [16:0] extra_tokens;
        logic [6:0]  layer;
        logic [15:0] position;
        logic [1:0]  store_sel;
    } kv_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [39:0] offset;
        logic [1:0]  store_used;
        logic [8:0]  blocks_held;
        logic [10:0] free_blocks;
    } kv_result_t;

    // Block manager predictor with its own pool, tables and register copies.
    class kv_scoreboard;
        logic [9:0]  free_ids[POOL_MAX];
        int unsigned free_count;
        logic [9:0]  slot_blocks[SLOTS * DEPTH];
        int unsigned fill[SLOTS];
        int unsigned layers, heads, hwidth, tpb, pool_reg, idx_width;
        kv_result_t  pending[$];
        int          errors;

        function int unsigned min_one(int unsigned v);
            return (v == 0) ? 1 : v;
        endfunction

        function int unsigned pool_blocks();
            int unsigned p;
            p = min_one(pool_reg);
            return (p > POOL_MAX) ? POOL_MAX : p;
        endfunction

        function void refill();
            int unsigned p;
            p = pool_blocks();
            for (int i = 0; i < p; i++)
                free_ids[i] = 10'(p - 1 - i);
            free_count = p;
            for (int s = 0; s < SLOTS; s++)
                fill[s] = 0;
        endfunction

        function new();
            layers = 1;
            heads = 1;
            hwidth = 128;
            tpb = 16;
            pool_reg = 1024;
            idx_width = 0;
            errors = 0;
            refill();
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_LAYER_COUNT: layers = val[7:0];
                REG_KV_HEADS:    heads = val[7:0];
                REG_HEAD_WIDTH:  hwidth = val[8:0];
                REG_TOKENS_BLK:  tpb = val[8:0];
                REG_POOL_BLOCKS:
                begin
                    pool_reg = val[10:0];
                    refill();
                end
                REG_IDX_WIDTH:   idx_width = val[10:0];
                default: ;
            endcase
        endfunction

        function int unsigned block_tokens();
            return min_one(tpb);
        endfunction

        function int unsigned held(int unsigned s);
            return fill[s % SLOTS];
        endfunction

        // Works out the result of an accepted command and queues it.
        function void note(kv_cmd_t c);
            kv_result_t  r;
            int unsigned s;
            longint unsigned bs, needed, blk, slot_pos, tw, stride;
            s = c.slot % SLOTS;
            bs = block_tokens();
            r = '0;
            r.status = ST_OK;
            case (c.command)
                CMD_RESERVE:
                begin
                    needed = (longint'(c.seq_length) + c.extra_tokens + bs - 1) / bs;
                    if (needed > DEPTH)
                        r.status = ST_TBL_FULL;
                    else
                    begin
                        while (fill[s] < needed && free_count > 0)
                        begin
                            free_count--;
                            slot_blocks[s * DEPTH + fill[s]] = free_ids[free_count];
                            fill[s]++;
                        end
                        if (fill[s] < needed)
                            r.status = ST_EXHAUSTED;
                    end
                end
                CMD_RELEASE:
                begin
                    for (int k = 0; k < fill[s]; k++)
                        if (free_count < POOL_MAX)
                        begin
                            free_ids[free_count] = slot_blocks[s * DEPTH + k];
                            free_count++;
                        end
                    fill[s] = 0;
                end
                CMD_TRANSLATE:
                begin
                    blk = c.position / bs;
                    slot_pos = c.position % bs;
                    r.store_used = (c.store_sel == STORE_INDEXER) ? STORE_INDEXER :
                                   (c.store_sel == STORE_VALUE) ? STORE_VALUE : STORE_KEY;
                    if (r.store_used == STORE_INDEXER && idx_width == 0)
                        r.status = ST_IDX_OFF;
                    else if (blk >= fill[s] || c.layer >= min_one(layers))
                        r.status = ST_UNMAPPED;
                    else
                    begin
                        tw = (r.store_used == STORE_INDEXER) ? longint'(idx_width) :
                             longint'(min_one(heads)) * min_one(hwidth);
                        stride = bs * tw;
                        r.offset = 40'(longint'(c.layer) * pool_blocks() * stride +
                                       longint'(slot_blocks[s * DEPTH + blk]) * stride +
                                       slot_pos * tw);
                    end
                end
                default: ;
            endcase
            r.blocks_held = 9'(fill[s]);
            r.free_blocks = 11'(free_count);
            pending.insert(pending.size(), r);
        endfunction

        // Compares one result transfer with the oldest expectation.
        function void check(kv_result_t got);
            kv_result_t want;
            if (pending.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.offset !== want.offset)
            begin
                $error("element_offset: expected %0d, actual %0d", want.offset, got.offset);
                errors++;
            end
            if (got.store_used !== want.store_used)
            begin
                $error("store_used: expected %0d, actual %0d", want.store_used,
                       got.store_used);
                errors++;
            end
            if (got.blocks_held !== want.blocks_held)
            begin
                $error("blocks_held: expected %0d, actual %0d", want.blocks_held,
                       got.blocks_held);
                errors++;
            end
            if (got.free_blocks !== want.free_blocks)
            begin
                $error("free_blocks: expected %0d, actual %0d", want.free_blocks,
                       got.free_blocks);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kv_scoreboard kv_sb;
    bit           steady;

    paged_kv_block_manager_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit well above the slowest correct run.
    initial
    begin
        #30ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random back-pressure, checking every accepted transfer.
    initial
    begin
        kv_result_t got;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.status      = m_tuser;
                got.offset      = m_tdata[39:0];
                got.store_used  = m_tdata[41:40];
                got.blocks_held = m_tdata[50:42];
                got.free_blocks = m_tdata[61:51];
                kv_sb.check(got);
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 13);
        end
    end

    function automatic kv_cmd_t mk(logic [1:0] command, logic [5:0] slot,
                                   logic [16:0] len, logic [16:0] extra,
                                   logic [6:0] layer, logic [15:0] pos,
                                   logic [1:0] store_sel);
        kv_cmd_t c;
        c.command = command;
        c.slot = slot;
        c.seq_length = len;
        c.extra_tokens = extra;
        c.layer = layer;
        c.position = pos;
        c.store_sel = store_sel;
        return c;
    endfunction

    task automatic send(kv_cmd_t c);
        while (!steady && $urandom_range(0, 99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, c.store_sel, c.position, c.layer, c.extra_tokens,
                     c.seq_length, c.slot};
        s_tuser  <= c.command;
        do
            @(posedge clk);
        while (!s_tready);
        kv_sb.note(c);
    endtask

    // Holds off new commands until every outstanding result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (kv_sb.pending.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        kv_sb.write_reg(idx, val);
    endtask

    task automatic set_regs(logic [31:0] lc, logic [31:0] kh, logic [31:0] hw,
                            logic [31:0] tb, logic [31:0] pb, logic [31:0] iw);
        drain();
        write_reg(REG_LAYER_COUNT, lc);
        write_reg(REG_KV_HEADS, kh);
        write_reg(REG_HEAD_WIDTH, hw);
        write_reg(REG_TOKENS_BLK, tb);
        write_reg(REG_POOL_BLOCKS, pb);
        write_reg(REG_IDX_WIDTH, iw);
    endtask

    // Mostly well-formed reserve/translate/release traffic with some raw noise.
    task automatic random_traffic(int count, int calm_from, int calm_to, int pause_at);
        kv_cmd_t     c;
        int unsigned r, bs, slot, span;
        for (int n = 0; n < count; n++)
        begin
            steady = (n >= calm_from && n < calm_to);
            if (n == pause_at)
                drain();
            bs = kv_sb.block_tokens();
            r = $urandom_range(0, 99);
            slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 11);
            c = mk(CMD_RESERVE, 6'(slot), 17'($urandom), 17'($urandom), 7'($urandom),
                   16'($urandom), 2'($urandom));
            if (r < 35)
            begin
                c.seq_length = 17'($urandom_range(0, bs * 12));
                c.extra_tokens = 17'($urandom_range(0, bs * 4));
                if ($urandom_range(0, 29) == 0)
                begin
                    c.seq_length = 17'($urandom);
                    c.extra_tokens = 17'($urandom);
                end
            end
            else if (r < 70)
            begin
                c.command = CMD_TRANSLATE;
                span = kv_sb.held(slot) * bs;
                if (span > 65536)
                    span = 65536;
                if (span > 0)
                    c.position = 16'($urandom_range(0, span - 1));
                c.layer = 7'($urandom_range(0, kv_sb.min_one(kv_sb.layers) - 1));
            end
            else if (r < 82)
                c.command = CMD_RELEASE;
            else if (r < 95)
                c.command = CMD_TRANSLATE;
            else
                c.command = 2'($urandom);
            send(c);
        end
        steady = 1'b0;
    endtask

    // Stimulus.
    initial
    begin
        kv_sb = new();
        steady = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: growth, translation on each store, the error answers.
        send(mk(CMD_RESERVE, 6'd0, 17'd0, 17'd0, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_RESERVE, 6'd0, 17'd100, 17'd28, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_TRANSLATE, 6'd0, 17'd0, 17'd0, 7'd0, 16'd127, STORE_KEY));
        send(mk(CMD_TRANSLATE, 6'd0, 17'd0, 17'd0, 7'd0, 16'd0, STORE_VALUE));
        send(mk(CMD_TRANSLATE, 6'd0, 17'd0, 17'd0, 7'd0, 16'd3, STORE_INDEXER));
        send(mk(CMD_TRANSLATE, 6'd0, 17'd0, 17'd0, 7'd0, 16'd77, STORE_SPARE));
        send(mk(CMD_TRANSLATE, 6'd0, 17'd0, 17'd0, 7'd0, 16'd128, STORE_KEY));
        send(mk(CMD_TRANSLATE, 6'd0, 17'd0, 17'd0, 7'd127, 16'd5, STORE_VALUE));
        send(mk(CMD_RESERVE, 6'd63, 17'h1FFFF, 17'h1FFFF, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_RESERVE, 6'd63, 17'd4096, 17'd0, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_TRANSLATE, 6'd63, 17'd0, 17'd0, 7'd0, 16'hFFFF, STORE_KEY));
        send(mk(CMD_TRANSLATE, 6'd63, 17'd0, 17'd0, 7'd0, 16'd4095, STORE_VALUE));
        send(mk(CMD_RESERVE, 6'd62, 17'd4000, 17'd96, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_RESERVE, 6'd61, 17'd0, 17'd4096, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_RESERVE, 6'd60, 17'd4096, 17'd0, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_RESERVE, 6'd0, 17'd50, 17'd0, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_RELEASE, 6'd60, 17'd0, 17'd0, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_RELEASE, 6'd63, 17'd0, 17'd0, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_IDLE_OP, 6'd5, 17'd9, 17'd9, 7'd9, 16'd9, STORE_VALUE));
        send(mk(CMD_TRANSLATE, 6'd63, 17'd0, 17'd0, 7'd0, 16'd0, STORE_KEY));
        drain();
        write_reg(REG_IDX_WIDTH, 32'd1024);
        send(mk(CMD_TRANSLATE, 6'd0, 17'd0, 17'd0, 7'd0, 16'd100, STORE_INDEXER));

        random_traffic(200, 40, 140, 170);

        // Small pool: exhaustion is common.
        set_regs(32'd4, 32'd2, 32'd64, 32'd8, 32'd40, 32'd32);
        random_traffic(200, -1, -1, -1);

        // Largest settings; offsets wrap at 40 bits.
        set_regs(32'd128, 32'd128, 32'd256, 32'd256, 32'd1024, 32'd1024);
        send(mk(CMD_RESERVE, 6'd9, 17'd65536, 17'd0, 7'd0, 16'd0, STORE_KEY));
        send(mk(CMD_TRANSLATE, 6'd9, 17'd0, 17'd0, 7'd127, 16'hFFFF, STORE_KEY));
        send(mk(CMD_TRANSLATE, 6'd9, 17'd0, 17'd0, 7'd127, 16'hFFFF, STORE_INDEXER));
        random_traffic(200, -1, -1, -1);

        // Zero registers act as one; an oversized pool is clipped.
        set_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd2047);
        random_traffic(60, -1, -1, -1);
        set_regs(32'd3, 32'd1, 32'd5, 32'd1, 32'd2047, 32'd7);
        random_traffic(150, -1, -1, -1);

        drain();
        repeat (100) @(posedge clk);
        if (kv_sb.errors == 0 && kv_sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
design/pkv_pkg.sv
design/pkv_ram.sv
design/pkv_div.sv
design/paged_kv_block_manager_core.sv
tb/tb_paged_kv_block_manager_core.sv
